// File: rtl/core/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types, constants and case tables of the marching squares contour block.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned CoordBits  = 20;
  localparam int unsigned CellBits   = 12;
  localparam int unsigned Channels   = 4;
  localparam int unsigned RowLimit   = 4096;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_ISO_LEVEL = 2'd0;
  localparam logic [1:0] CFG_CHANNEL   = 2'd1;
  localparam logic [1:0] CFG_WIDTH     = 2'd2;
  localparam logic [1:0] CFG_HEIGHT    = 2'd3;

  typedef enum logic {
    F_IN,
    F_CLS
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SETUP,
    B_DIV,
    B_POINT
  } back_state_e;

  // One classified cell, handed from the front to the back
  typedef struct packed {
    logic [SampleBits-1:0] v0;
    logic [SampleBits-1:0] v1;
    logic [SampleBits-1:0] v2;
    logic [SampleBits-1:0] v3;
    logic [SampleBits-1:0] iso;
    logic [3:0]            code;  // reduced case, 1..8
    logic [CellBits-1:0]   x;
    logic [CellBits-1:0]   y;
  } cell_t;

  // Corner offsets: corner 0 (0,0), 1 (1,0), 2 (1,1), 3 (0,1)
  function automatic logic corner_x(input logic [1:0] c);
    return (c == 2'd1) || (c == 2'd2);
  endfunction

  function automatic logic corner_y(input logic [1:0] c);
    return (c == 2'd2) || (c == 2'd3);
  endfunction

  // Number of segments of a reduced case
  function automatic logic [1:0] seg_count(input logic [3:0] code);
    logic [1:0] n;
    case (code)
      4'd5, 4'd8: n = 2'd2;
      4'd0:       n = 2'd0;
      default:    n = 2'd1;
    endcase
    return n;
  endfunction

  // Edge {a,b} for end point pt (0..3) of a reduced case
  function automatic logic [3:0] seg_edge(input logic [3:0] code, input logic [1:0] pt);
    logic [15:0] row;
    case (code)
      4'd1:    row = {2'd0, 2'd1, 2'd0, 2'd3, 8'd0};
      4'd2:    row = {2'd0, 2'd1, 2'd1, 2'd2, 8'd0};
      4'd3:    row = {2'd0, 2'd3, 2'd1, 2'd2, 8'd0};
      4'd4:    row = {2'd2, 2'd3, 2'd2, 2'd1, 8'd0};
      4'd5:    row = {2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};
      4'd6:    row = {2'd0, 2'd1, 2'd2, 2'd3, 8'd0};
      4'd7:    row = {2'd0, 2'd3, 2'd3, 2'd2, 8'd0};
      4'd8:    row = {2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
      default: row = 16'd0;
    endcase
    return row[15 - 4*pt -: 4];
  endfunction

endpackage

// File: rtl/core/msq_front.sv
// ----------------------------------------------------------------------------
// msq_front
// Pixel intake, line store and cell classification.
// ----------------------------------------------------------------------------
module msq_front import msq_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SampleBits-1:0] iso_level_i,
  input  logic [1:0]            channel_i,
  input  logic [12:0]           width_i,
  input  logic [12:0]           height_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] sample_ch0_i,
  input  logic [SampleBits-1:0] sample_ch1_i,
  input  logic [SampleBits-1:0] sample_ch2_i,
  input  logic [SampleBits-1:0] sample_ch3_i,
  output logic                  push_o,
  output cell_t                 cell_o,
  input  logic                  full_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(RowLimit);
  localparam logic [1:0]  LastCh = 2'(Channels - 1);

  logic [SampleBits-1:0] mem [MAX_WIDTH];

  front_state_e          state_q, state_d;
  logic [SampleBits-1:0] cur_q, up_q, left_q, ul_q;
  logic [CellBits-1:0]   col_q, row_q;
  logic [SampleBits-1:0] cur_sel;
  logic [1:0]            ch;
  logic                  accept, commit, closes;
  logic [3:0]            raw, code;
  logic [SampleBits+1:0] sum, iso4;
  logic [12:0]           w_eff, h_eff, col_inc, row_inc;

  assign ch = (channel_i > LastCh) ? LastCh : channel_i;
  always_comb begin
    case (ch)
      2'd0:    cur_sel = sample_ch0_i;
      2'd1:    cur_sel = sample_ch1_i;
      2'd2:    cur_sel = sample_ch2_i;
      default: cur_sel = sample_ch3_i;
    endcase
  end

  assign in_ready_o = (state_q == F_IN);
  assign accept     = in_valid_i && in_ready_o;

  // Classify: corner 0 upper left, 1 upper right, 2 current, 3 left
  always_comb begin
    raw[0] = ul_q   >= iso_level_i;
    raw[1] = up_q   >= iso_level_i;
    raw[2] = cur_q  >= iso_level_i;
    raw[3] = left_q >= iso_level_i;
    sum  = {2'b00, ul_q} + {2'b00, up_q} + {2'b00, cur_q} + {2'b00, left_q};
    iso4 = {iso_level_i, 2'b00};
    if (raw == 4'd5) begin
      code = (sum >= iso4) ? 4'd5 : 4'd8;
    end else if (raw == 4'd10) begin
      code = (sum >= iso4) ? 4'd8 : 4'd5;
    end else if (raw > 4'd7) begin
      code = 4'd15 - raw;
    end else begin
      code = raw;
    end
  end

  assign closes = (col_q != '0) && (row_q != '0) && (code != 4'd0);
  assign push_o = (state_q == F_CLS) && closes && !full_i;
  assign commit = (state_q == F_CLS) && (!closes || !full_i);

  assign cell_o.v0   = ul_q;
  assign cell_o.v1   = up_q;
  assign cell_o.v2   = cur_q;
  assign cell_o.v3   = left_q;
  assign cell_o.iso  = iso_level_i;
  assign cell_o.code = code;
  assign cell_o.x    = col_q - 1'b1;
  assign cell_o.y    = row_q - 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IN:    if (accept) state_d = F_CLS;
      F_CLS:   if (commit) state_d = F_IN;
      default: state_d = F_IN;
    endcase
  end

  assign w_eff   = (width_i == '0 || width_i > MaxW) ? MaxW : width_i;
  assign h_eff   = (height_i == '0 || height_i > MaxH) ? MaxH : height_i;
  assign col_inc = {1'b0, col_q} + 13'd1;
  assign row_inc = {1'b0, row_q} + 13'd1;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= cur_sel;
      up_q  <= mem[col_q[AW-1:0]];
    end
    if (commit) begin
      mem[col_q[AW-1:0]] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IN;
      left_q  <= '0;
      ul_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        left_q <= cur_q;
        ul_q   <= up_q;
        if (col_inc >= w_eff) begin
          col_q <= '0;
          row_q <= (row_inc >= h_eff) ? '0 : row_inc[CellBits-1:0];
        end else begin
          col_q <= col_inc[CellBits-1:0];
        end
      end
    end
  end

endmodule

// File: rtl/core/msq_queue.sv
// ----------------------------------------------------------------------------
// msq_queue
// Two-entry queue of classified cells between front and back.
// ----------------------------------------------------------------------------
module msq_queue import msq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cell_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output cell_t data_o
);

  cell_t      entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: rtl/core/msq_back.sv
// ----------------------------------------------------------------------------
// msq_back
// Segment sequencer: serial edge interpolation and output register.
// ----------------------------------------------------------------------------
module msq_back import msq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  cell_t                cell_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CoordBits-1:0] start_x_o,
  output logic [CoordBits-1:0] start_y_o,
  output logic [CoordBits-1:0] end_x_o,
  output logic [CoordBits-1:0] end_y_o,
  output logic [CellBits-1:0]  cell_column_o,
  output logic [CellBits-1:0]  cell_row_o,
  output logic                 last_of_cell_o
);

  localparam logic [FracBits:0] One = (FracBits+1)'(1) << FracBits;
  localparam int unsigned CW = $clog2(FracBits);

  back_state_e           state_q, state_d;
  cell_t                 rec_q;
  logic [1:0]            pt_q;
  logic [SampleBits-1:0] den_q, rem_q;
  logic [FracBits:0]     frac_q;
  logic [CW-1:0]         cnt_q;
  logic [CoordBits-1:0]  sx_q, sy_q;
  logic                  out_valid_q, out_free, last_pt;
  logic [3:0]            ab;
  logic [1:0]            ca, cb;
  logic [SampleBits-1:0] va, vb, num, den;
  logic [SampleBits:0]   rem2;
  logic [CoordBits-1:0]  px, py;

  function automatic logic [SampleBits-1:0] pick(input cell_t r, input logic [1:0] c);
    logic [SampleBits-1:0] v;
    case (c)
      2'd0:    v = r.v0;
      2'd1:    v = r.v1;
      2'd2:    v = r.v2;
      default: v = r.v3;
    endcase
    return v;
  endfunction

  function automatic logic [CoordBits-1:0] coord(input logic [CellBits-1:0] idx,
                                                 input logic oa, input logic ob,
                                                 input logic [FracBits:0] f);
    logic [CoordBits+1:0] base;
    base = ({(CoordBits+2-CellBits)'(0), idx} + (CoordBits+2)'(oa)) << FracBits;
    if (ob && !oa) base = base + (CoordBits+2)'(f);
    else if (oa && !ob) base = base - (CoordBits+2)'(f);
    return base[CoordBits-1:0];
  endfunction

  assign ab   = seg_edge(rec_q.code, pt_q);
  assign ca   = ab[3:2];
  assign cb   = ab[1:0];
  assign va   = pick(rec_q, ca);
  assign vb   = pick(rec_q, cb);
  assign num  = (rec_q.iso > va) ? rec_q.iso - va : va - rec_q.iso;
  assign den  = (vb > va) ? vb - va : va - vb;
  assign rem2 = {rem_q, 1'b0};
  assign px   = coord(rec_q.x, corner_x(ca), corner_x(cb), frac_q);
  assign py   = coord(rec_q.y, corner_y(ca), corner_y(cb), frac_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign last_pt  = (pt_q == {seg_count(rec_q.code) == 2'd2, 1'b1});
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_SETUP;
      B_SETUP: if (den != '0 && num < den) state_d = B_DIV; else state_d = B_POINT;
      B_DIV:   if (cnt_q == '0) state_d = B_POINT;
      B_POINT: begin
        if (!pt_q[0]) state_d = B_SETUP;
        else if (out_free) state_d = last_pt ? B_IDLE : B_SETUP;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath: restoring divide, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (!empty_i) rec_q <= cell_i;
      B_SETUP: begin
        den_q  <= den;
        rem_q  <= num;
        cnt_q  <= CW'(FracBits - 1);
        frac_q <= (den == '0) ? '0 : ((num >= den) ? One : '0);
      end
      B_DIV: begin
        cnt_q <= cnt_q - 1'b1;
        if (rem2 >= {1'b0, den_q}) begin
          rem_q  <= rem2[SampleBits-1:0] - den_q;
          frac_q <= {frac_q[FracBits-1:0], 1'b1};
        end else begin
          rem_q  <= rem2[SampleBits-1:0];
          frac_q <= {frac_q[FracBits-1:0], 1'b0};
        end
      end
      B_POINT: begin
        if (!pt_q[0]) begin
          sx_q <= px;
          sy_q <= py;
        end else if (out_free) begin
          start_x_o      <= sx_q;
          start_y_o      <= sy_q;
          end_x_o        <= px;
          end_y_o        <= py;
          cell_column_o  <= rec_q.x;
          cell_row_o     <= rec_q.y;
          last_of_cell_o <= last_pt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pt_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_IDLE) begin
        pt_q <= 2'd0;
      end else if (state_q == B_POINT && (!pt_q[0] || out_free)) begin
        pt_q <= pt_q + 2'd1;
      end
      if (state_q == B_POINT && pt_q[0] && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_POINT |-> frac_q <= One)
    else $error("interpolation fraction beyond one pixel");

  a_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_SETUP |-> rec_q.code != 4'd0 && rec_q.code <= 4'd8)
    else $error("cell with no segments reached the back");

  a_pt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_SETUP && seg_count(rec_q.code) == 2'd1 |-> !pt_q[1])
    else $error("end point beyond the segment count");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == B_SETUP && pt_q == 2'd0)
    else $error("cell popped without starting at its first point");

endmodule

// File: rtl/core/marching_squares_contour.sv
// ----------------------------------------------------------------------------
// marching_squares_contour
// Marching squares isoline extractor over a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  config   | cfg_we_i                | cfg_index_i, cfg_data_i
//  pixel in | in_valid_i / in_ready_o | sample_ch0_i .. sample_ch3_i
//  segment  | out_valid_o/out_ready_i | start/end x,y, cell_column/row, last
//
//  The front reads the line store for a pixel, then classifies and writes
//  back; it takes no new pixel until that cell is committed. In the back
//  each end point passes a set-up state, FracBits divide steps and a point
//  state, skipping the divide steps when it needs no division. A cell is
//  popped in the idle state; an output stall holds the back at the end point.
//  Reset clears position counters, left and upper-left samples and all handshake
//  state; the line store is left as it is and is written before any cell
//  uses it. A two-entry cell queue lets the front run on while the back or
//  the output stalls; the front holds only when it must push into a full queue.
// ----------------------------------------------------------------------------
module marching_squares_contour import msq_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] sample_ch0_i,
  input  logic [SampleBits-1:0] sample_ch1_i,
  input  logic [SampleBits-1:0] sample_ch2_i,
  input  logic [SampleBits-1:0] sample_ch3_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CoordBits-1:0]  start_x_o,
  output logic [CoordBits-1:0]  start_y_o,
  output logic [CoordBits-1:0]  end_x_o,
  output logic [CoordBits-1:0]  end_y_o,
  output logic [CellBits-1:0]   cell_column_o,
  output logic [CellBits-1:0]   cell_row_o,
  output logic                  last_of_cell_o
);

  logic [15:0] iso_q;
  logic [1:0]  chan_q;
  logic [12:0] width_q, height_q;

  logic  push, full, pop, empty;
  cell_t cell_in, cell_out;

  // Configuration regs, write only: user writes while block is idle; unenforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q    <= 16'd32768;
      chan_q   <= 2'd0;
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ISO_LEVEL: iso_q    <= cfg_data_i;
        CFG_CHANNEL:   chan_q   <= cfg_data_i[1:0];
        CFG_WIDTH:     width_q  <= cfg_data_i[12:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Front: intake, line store, classification
  msq_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .iso_level_i (iso_q),
    .channel_i   (chan_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .in_valid_i,
    .in_ready_o,
    .sample_ch0_i,
    .sample_ch1_i,
    .sample_ch2_i,
    .sample_ch3_i,
    .push_o      (push),
    .cell_o      (cell_in),
    .full_i      (full)
  );

  // Decouple: hold classified cells while the back is busy
  msq_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (cell_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cell_out)
  );

  // Back: interpolate end points, transfer segments
  msq_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .cell_i  (cell_out),
    .pop_o   (pop),
    .out_valid_o,
    .out_ready_i,
    .start_x_o,
    .start_y_o,
    .end_x_o,
    .end_y_o,
    .cell_column_o,
    .cell_row_o,
    .last_of_cell_o
  );

endmodule
